// ===== hw/rtl/mme_pkg.sv =====
// Shared types and constants of the matrix multiply engine.
`timescale 1ns / 1ps
`default_nettype none

package mme_pkg;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 16;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int RND_SHIFT = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A = 2'd0,
        CFG_INNER  = 2'd1,
        CFG_COLS_B = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_ROUND,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/mme_in_if.sv =====
// Input channel of the matrix multiply engine: valid, ready and one load or compute item.
`timescale 1ns / 1ps
`default_nettype none

interface mme_in_if;
    import mme_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] element_value;

    modport source (output valid, output operation, output row_index,
                    output col_index, output element_value, input ready);
    modport sink   (input valid, input operation, input row_index,
                    input col_index, input element_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mme_out_if.sv =====
// Result channel of the matrix multiply engine: valid, ready and one result item.
`timescale 1ns / 1ps
`default_nettype none

interface mme_out_if;
    import mme_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] product_value;
    logic                    status;
    logic                    saturated;

    modport source (output valid, output product_value, output status,
                    output saturated, input ready);
    modport sink   (input valid, input product_value, input status,
                    input saturated, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/matrix_multiply_engine_unit.sv =====
// Top level of the matrix multiply engine: element stores and one shared multiply-accumulate unit.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   i_in carries items: write an element of A, write an element of B, or
//   compute C[row][col]. Every item gives exactly one result on o_out:
//   writes and errors answer zero with a status bit, a compute answers the
//   Q8.8 dot product of row `row` of A and column `col` of B, rounded and
//   clipped to 16 bits.
//   Sizes come from the write port i_cfg_*; change them only when idle.
// Timing
//   A write passes from idle through S_RESULT to the output register. A
//   compute issues its element pairs one at a time, inner_size capped at
//   MAX_DIM pairs in all (none when zero), to a single 16x16 multiplier and
//   accumulator; the read, multiply and add stages drain, S_ROUND rounds
//   and the clip loads the output register. i_in.ready is high only while
//   the sequencer is idle: no item is taken until the last result is loaded.
// Reset
//   Clears the sequencer, the pipeline and output valid flags, and sets all sizes to 1.
//   The element stores are not cleared; read only written elements.
// Stall
//   A result waits in the output register; the next item is still taken,
//   and its own result waits until the held one has been transferred.

module matrix_multiply_engine_unit #(
    parameter int MAX_DIM = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    mme_in_if.sink                           i_in,
    mme_out_if.source                        o_out,
    input  wire                              i_cfg_we,
    input  wire [mme_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [mme_pkg::CFG_W-1:0]         i_cfg_data
);
    import mme_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW     = $clog2(MAX_DIM + 1);
    localparam int SZ_W   = (KW > CFG_W) ? KW : CFG_W;
    localparam int AC_W   = 16;                  // holds 16*16+15, the largest raw address at MAX_DIM = 16
    localparam int ACC_W  = PROD_W + KW;

    localparam logic [SZ_W-1:0]         MAX_SZ = SZ_W'(MAX_DIM);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (RND_SHIFT - 1));

    // Configuration
    logic [CFG_W-1:0] r_rows_a, r_inner, r_cols_b;

    // Sequencer and item registers
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_row, r_col;
    logic [KW-1:0]    r_k;
    logic             r_err;
    logic             r_is_cmp;
    logic             r_rd_vld, r_mul_vld;

    // Datapath
    logic signed [VAL_W-1:0]  r_a_q, r_b_q;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    // Output register
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_out_status, r_out_sat;

    // Element stores
    logic [VAL_W-1:0] mem_a [DEPTH];
    logic [VAL_W-1:0] mem_b [DEPTH];

    logic [SZ_W-1:0]   w_nr, w_nk, w_nc;
    logic [SZ_W-1:0]   w_in_row, w_in_col;
    t_op               w_op;
    logic              w_take;
    logic              w_issue;
    logic              w_load_out;
    logic              w_drained;
    logic              w_wr_a, w_wr_b, w_in_err;
    logic [AC_W-1:0]   w_waddr_full, w_raddr_a_full, w_raddr_b_full;
    logic [ADDR_W-1:0] w_waddr, w_raddr_a, w_raddr_b;
    logic signed [VAL_W-1:0] w_clip;
    logic              w_clip_sat;

    // Sizes above the store dimension act as the store dimension.
    assign w_nr = (SZ_W'(r_rows_a) > MAX_SZ) ? MAX_SZ : SZ_W'(r_rows_a);
    assign w_nk = (SZ_W'(r_inner)  > MAX_SZ) ? MAX_SZ : SZ_W'(r_inner);
    assign w_nc = (SZ_W'(r_cols_b) > MAX_SZ) ? MAX_SZ : SZ_W'(r_cols_b);

    assign w_in_row = SZ_W'(i_in.row_index);
    assign w_in_col = SZ_W'(i_in.col_index);
    assign w_op     = t_op'(i_in.operation);

    assign i_in.ready = (r_state == S_IDLE);
    assign w_take     = i_in.valid && (r_state == S_IDLE);

    // Decode the incoming item: store enables and range error.
    always_comb begin
        w_wr_a   = 1'b0;
        w_wr_b   = 1'b0;
        w_in_err = 1'b0;
        case (w_op)
            OP_WRITE_A: begin
                w_wr_a   = (w_in_row < w_nr) && (w_in_col < w_nk);
                w_in_err = !w_wr_a;
            end
            OP_WRITE_B: begin
                w_wr_b   = (w_in_row < w_nk) && (w_in_col < w_nc);
                w_in_err = !w_wr_b;
            end
            OP_COMPUTE: begin
                w_in_err = !((w_in_row < w_nr) && (w_in_col < w_nc));
            end
            default: begin
                w_in_err = 1'b1;
            end
        endcase
    end

    // Element (r,c) lives at r*MAX_DIM+c; in range it stays below DEPTH.
    assign w_waddr_full   = AC_W'(i_in.row_index) * AC_W'(MAX_DIM) + AC_W'(i_in.col_index);
    assign w_raddr_a_full = AC_W'(r_row) * AC_W'(MAX_DIM) + AC_W'(r_k);
    assign w_raddr_b_full = AC_W'(r_k) * AC_W'(MAX_DIM) + AC_W'(r_col);
    assign w_waddr   = w_waddr_full[ADDR_W-1:0];
    assign w_raddr_a = w_raddr_a_full[ADDR_W-1:0];
    assign w_raddr_b = w_raddr_b_full[ADDR_W-1:0];

    assign w_issue   = (r_state == S_RUN) && (SZ_W'(r_k) < w_nk);
    assign w_drained = !w_issue && !r_rd_vld && !r_mul_vld;
    assign w_load_out = (r_state == S_RESULT) && (!r_out_valid || o_out.ready);

    // Clip the rounded sum to 16 bits.
    always_comb begin
        w_clip_sat = 1'b0;
        w_clip     = r_acc[VAL_W-1:0];
        if (r_acc > SAT_HI) begin
            w_clip     = SAT_HI[VAL_W-1:0];
            w_clip_sat = 1'b1;
        end else if (r_acc < SAT_LO) begin
            w_clip     = SAT_LO[VAL_W-1:0];
            w_clip_sat = 1'b1;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_state = (w_op == OP_COMPUTE && !w_in_err) ? S_RUN : S_RESULT;
                end
            end
            S_RUN: begin
                if (w_drained) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Size registers; an index past the last register is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= CFG_RESET;
            r_inner  <= CFG_RESET;
            r_cols_b <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROWS_A: r_rows_a <= i_cfg_data;
                CFG_INNER:  r_inner  <= i_cfg_data;
                CFG_COLS_B: r_cols_b <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Element stores: written on transfer, read one pair a cycle while running.
    always_ff @(posedge i_clk) begin
        if (w_take && w_wr_a) begin
            mem_a[w_waddr] <= i_in.element_value;
        end
        r_a_q <= mem_a[w_raddr_a];
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_wr_b) begin
            mem_b[w_waddr] <= i_in.element_value;
        end
        r_b_q <= mem_b[w_raddr_b];
    end

    // Multiply-accumulate pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_mul_vld <= 1'b0;
        end else begin
            r_rd_vld  <= w_issue;
            r_mul_vld <= r_rd_vld;
        end
    end

    // Item registers, inner counter and accumulator
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_row    <= i_in.row_index;
            r_col    <= i_in.col_index;
            r_err    <= w_in_err;
            r_is_cmp <= (w_op == OP_COMPUTE) && !w_in_err;
            r_k      <= '0;
            r_acc    <= '0;
        end else begin
            if (w_issue) begin
                r_k <= r_k + KW'(1);
            end
            if (r_mul_vld) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end else if (r_state == S_ROUND) begin
                // Round to nearest, ties upward, then drop the fraction bits.
                r_acc <= (r_acc + RND_HALF) >>> RND_SHIFT;
            end
        end
        r_prod <= r_a_q * r_b_q;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_value  <= r_is_cmp ? w_clip : '0;
            r_out_sat    <= r_is_cmp && w_clip_sat;
            r_out_status <= r_err;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.product_value = r_out_value;
    assign o_out.status        = r_out_status;
    assign o_out.saturated     = r_out_sat;

endmodule

`default_nettype wire

// ===== bench/matrix_multiply_engine_unit_tb.sv =====
// Self-checking bench for the matrix multiply engine: directed table, then random load/compute sessions.
`timescale 1ns / 1ps

module matrix_multiply_engine_unit_tb;
    import mme_pkg::*;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int DIM           = 16;      // store side, as built into the block
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 3;       // quiet cycles before a size write
    localparam int TAIL_CYCLES   = 40;      // longer than one full-depth compute
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LOAD_BUDGET   = 160;     // most element writes one session may need
    localparam int PHASE1_END    = 600;
    localparam int PHASE2_END    = 1150;
    localparam int ITEM_TARGET   = 1700;
    localparam int N_SCRIPT      = 28;

    // Codes the package leaves without a name: the spare operation and the
    // spare register index, both of which the block must reject or ignore.
    localparam logic [OP_W-1:0]      OP_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // One answer of the block, as the result channel carries it.
    typedef struct packed {
        logic [VAL_W-1:0] product;
        logic             status;
        logic             saturated;
    } t_answer;

    localparam t_answer ANS_OK  = '{16'h0000, 1'b0, 1'b0};
    localparam t_answer ANS_ERR = '{16'h0000, 1'b1, 1'b0};

    // One row of the directed table: either a size write or an item, the
    // latter optionally with its answer typed in.
    typedef struct packed {
        logic                 is_cfg;
        logic [OP_W-1:0]      code;     // operation, or register index
        logic [IDX_W-1:0]     row;
        logic [IDX_W-1:0]     col;
        logic [VAL_W-1:0]     value;    // element, or register data in [4:0]
        logic                 typed;
        t_answer              want;
    } t_step;

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    mme_in_if  in_ch ();
    mme_out_if out_ch ();

    matrix_multiply_engine_unit #(
        .MAX_DIM    (DIM)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow state of the engine: both element stores, which entries have
    // been loaded, and the three size registers.
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] a_elems  [DIM*DIM];
    logic [VAL_W-1:0] b_elems  [DIM*DIM];
    bit               a_loaded [DIM*DIM];
    bit               b_loaded [DIM*DIM];
    logic [CFG_W-1:0] rows_cfg  = CFG_RESET;
    logic [CFG_W-1:0] inner_cfg = CFG_RESET;
    logic [CFG_W-1:0] cols_cfg  = CFG_RESET;

    t_answer answers_due [$];     // answers owed by the block, oldest first

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int cycle_count  = 0;
    int mismatch_count  = 0;
    int items_sent      = 0;
    int answers_checked = 0;
    int products_ok     = 0;
    int products_sat    = 0;
    int rejected_items  = 0;
    int size_writes     = 0;

    t_step script [N_SCRIPT];

    // A size register above the store side behaves as the full side.
    function automatic int dim(logic [CFG_W-1:0] s);
        return (s > DIM) ? DIM : int'(s);
    endfunction

    function automatic int slot(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
        return int'(r) * DIM + int'(c);
    endfunction

    // Answer to one item under the current sizes; writes land in the shadow
    // stores. Products are summed at full Q16.16 precision, then rounded to
    // nearest with ties upward and clipped to 16 bits.
    function automatic t_answer engine_answer(logic [OP_W-1:0] op, logic [IDX_W-1:0] r,
                                              logic [IDX_W-1:0] c, logic [VAL_W-1:0] v);
        t_answer ans;
        int      nr, nk, nc, k;
        longint  acc;
        ans = ANS_OK;
        nr  = dim(rows_cfg);
        nk  = dim(inner_cfg);
        nc  = dim(cols_cfg);
        acc = 0;
        case (op)
            OP_WRITE_A: begin
                if (r < nr && c < nk) begin
                    a_elems[slot(r, c)]  = v;
                    a_loaded[slot(r, c)] = 1'b1;
                end else begin
                    ans.status = 1'b1;
                end
            end
            OP_WRITE_B: begin
                if (r < nk && c < nc) begin
                    b_elems[slot(r, c)]  = v;
                    b_loaded[slot(r, c)] = 1'b1;
                end else begin
                    ans.status = 1'b1;
                end
            end
            OP_COMPUTE: begin
                if (r < nr && c < nc) begin
                    for (k = 0; k < nk; k++)
                        acc += longint'($signed(a_elems[int'(r) * DIM + k]))
                             * longint'($signed(b_elems[k * DIM + int'(c)]));
                    acc = (acc + 128) >>> 8;
                    if (acc > 32767) begin
                        acc = 32767;
                        ans.saturated = 1'b1;
                    end else if (acc < -32768) begin
                        acc = -32768;
                        ans.saturated = 1'b1;
                    end
                    ans.product = acc[15:0];
                end else begin
                    ans.status = 1'b1;
                end
            end
            default: ans.status = 1'b1;
        endcase
        return ans;
    endfunction

    // True when a compute of (r, c) touches only loaded entries, or none.
    function automatic bit reads_loaded_only(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
        int k;
        if (r >= dim(rows_cfg) || c >= dim(cols_cfg))
            return 1'b1;
        for (k = 0; k < dim(inner_cfg); k++)
            if (!a_loaded[int'(r) * DIM + k] || !b_loaded[k * DIM + int'(c)])
                return 1'b0;
        return 1'b1;
    endfunction

    // Element values: mostly small or medium so that sums stay in range,
    // with extremes and full-width values to drive clipping.
    function automatic logic [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            case ($urandom_range(0, 5))
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'h0000;
                3:       return 16'hFFFF;
                4:       return 16'h0100;
                default: return 16'hFF00;
            endcase
        end else if (roll < 45) begin
            return 16'($urandom_range(0, 16'h0400) - 32'h0200);
        end else if (roll < 70) begin
            return 16'($urandom_range(0, 16'h1000) - 32'h0800);
        end
        return 16'($urandom);
    endfunction

    // Sizes: mostly small, with zero, the full side and oversize settings.
    function automatic logic [CFG_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return 5'd0;
        else if (roll < 12)
            return 5'($urandom_range(17, 31));
        else if (roll < 22)
            return 5'd16;
        else if (roll < 35)
            return 5'($urandom_range(5, 15));
        return 5'($urandom_range(1, 4));
    endfunction

    task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
        $display("[%0t] mismatch, %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one item, idling first at the current rate, and hold it until
    // the transfer. The answer is worked out at the transfer edge; a typed
    // answer takes its place where the table gives one.
    task automatic send_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                             logic [VAL_W-1:0] v, logic typed, t_answer typed_ans);
        t_answer ans;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= op;
        in_ch.row_index     <= r;
        in_ch.col_index     <= c;
        in_ch.element_value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        ans = engine_answer(op, r, c, v);
        if (typed)
            ans = typed_ans;
        answers_due.insert(answers_due.size(), ans);
        items_sent++;
        if (ans.status)
            rejected_items++;
        else if (op == OP_COMPUTE) begin
            products_ok++;
            if (ans.saturated)
                products_sat++;
        end
    endtask

    // Random fields on every input; a compute that would read an entry
    // never loaded is turned into the spare operation instead.
    task automatic send_noise();
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] r, c;
        op = 2'($urandom_range(0, 3));
        r  = 4'($urandom);
        c  = 4'($urandom);
        if (op == OP_COMPUTE && !reads_loaded_only(r, c))
            op = OP_SPARE;
        send_item(op, r, c, 16'($urandom), 1'b0, ANS_OK);
    endtask

    // Drop valid and hold off until every owed answer has been transferred.
    task automatic await_answers();
        in_ch.valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Size registers change only with the block idle.
    task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        await_answers();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        size_writes++;
        case (idx)
            CFG_ROWS_A: rows_cfg  = data;
            CFG_INNER:  inner_cfg = data;
            CFG_COLS_B: cols_cfg  = data;
            default: ;
        endcase
    endtask

    // One session: set the three sizes, load A then B in row-major order
    // with stray items mixed in, then a run of computes and reloads. Now
    // and then the load leaves entries out, so that only the computes it
    // still supports are issued.
    task automatic run_session();
        logic [CFG_W-1:0] sr, sk, sc;
        logic [IDX_W-1:0] r, c;
        int               nr, nk, nc, i, n_comp, roll;
        bit               partial;
        do begin
            sr = pick_size();
            sk = pick_size();
            sc = pick_size();
        end while (dim(sr) * dim(sk) + dim(sk) * dim(sc) > LOAD_BUDGET);
        write_size(CFG_ROWS_A, sr);
        write_size(CFG_INNER, sk);
        write_size(CFG_COLS_B, sc);
        if ($urandom_range(0, 9) == 0)
            write_size(CFG_SPARE, 5'($urandom));
        nr      = dim(sr);
        nk      = dim(sk);
        nc      = dim(sc);
        partial = ($urandom_range(0, 6) == 0);

        for (i = 0; i < nr * nk; i++) begin
            if (partial && $urandom_range(0, 7) == 0)
                continue;
            if ($urandom_range(0, 99) < 8)
                send_noise();
            send_item(OP_WRITE_A, 4'(i / nk), 4'(i % nk), pick_value(), 1'b0, ANS_OK);
        end
        for (i = 0; i < nk * nc; i++) begin
            if (partial && $urandom_range(0, 7) == 0)
                continue;
            if ($urandom_range(0, 99) < 8)
                send_noise();
            send_item(OP_WRITE_B, 4'(i / nc), 4'(i % nc), pick_value(), 1'b0, ANS_OK);
        end

        n_comp = $urandom_range(4, 16);
        for (i = 0; i < n_comp; i++) begin
            roll = $urandom_range(0, 9);
            r    = (nr > 0) ? 4'($urandom_range(0, nr - 1)) : 4'd0;
            c    = (nc > 0) ? 4'($urandom_range(0, nc - 1)) : 4'd0;
            if (roll < 7 && nr > 0 && nc > 0 && reads_loaded_only(r, c))
                send_item(OP_COMPUTE, r, c, 16'($urandom), 1'b0, ANS_OK);
            else if (roll < 8 && nr > 0 && nk > 0)
                send_item(OP_WRITE_A, r, 4'($urandom_range(0, nk - 1)), pick_value(),
                          1'b0, ANS_OK);
            else if (roll < 9 && nk > 0 && nc > 0)
                send_item(OP_WRITE_B, 4'($urandom_range(0, nk - 1)), c, pick_value(),
                          1'b0, ANS_OK);
            else
                send_noise();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: ready toggles at the current stall rate; every transfer
    // is matched against the oldest owed answer, field by field.
    // ------------------------------------------------------------------
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_answer due;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (answers_due.size() == 0) begin
                report_mismatch("result with no answer owed", out_ch.product_value, 16'h0);
            end else begin
                due = answers_due.pop_front();
                answers_checked++;
                if (out_ch.product_value !== due.product)
                    report_mismatch("product_value", out_ch.product_value, due.product);
                if (out_ch.status !== due.status)
                    report_mismatch("status", 16'(out_ch.status), 16'(due.status));
                if (out_ch.saturated !== due.saturated)
                    report_mismatch("saturated", 16'(out_ch.saturated), 16'(due.saturated));
            end
        end
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("cycle limit reached with %0d answers still owed", answers_due.size());
            $display("matrix_multiply_engine_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        in_ch.valid         = 1'b0;
        in_ch.operation     = OP_WRITE_A;
        in_ch.row_index     = '0;
        in_ch.col_index     = '0;
        in_ch.element_value = '0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_ROWS_A;
        i_cfg_data          = '0;
        i_rst_n             = 1'b0;

        // Directed table. Sizes start at 1 x 1 x 1. Covers clipping at both
        // ends, unity product, both rounding ties, every rejection, the
        // spare operation, a zero inner size (empty sum), the ignored
        // register index and oversize registers acting as the full side.
        script = '{
            '{1'b0, OP_WRITE_A, 4'h0, 4'h0, 16'h7FFF, 1'b1, ANS_OK},
            '{1'b0, OP_WRITE_B, 4'h0, 4'h0, 16'h7FFF, 1'b1, ANS_OK},
            '{1'b0, OP_COMPUTE, 4'h0, 4'h0, 16'h0000, 1'b1, '{16'h7FFF, 1'b0, 1'b1}},
            '{1'b0, OP_WRITE_B, 4'h0, 4'h0, 16'h8000, 1'b1, ANS_OK},
            '{1'b0, OP_COMPUTE, 4'h0, 4'h0, 16'h0000, 1'b1, '{16'h8000, 1'b0, 1'b1}},
            '{1'b0, OP_WRITE_A, 4'h0, 4'h0, 16'h0100, 1'b1, ANS_OK},
            '{1'b0, OP_WRITE_B, 4'h0, 4'h0, 16'h0100, 1'b1, ANS_OK},
            '{1'b0, OP_COMPUTE, 4'h0, 4'h0, 16'hFFFF, 1'b1, '{16'h0100, 1'b0, 1'b0}},
            '{1'b0, OP_WRITE_A, 4'h0, 4'h0, 16'h0001, 1'b0, ANS_OK},
            '{1'b0, OP_WRITE_B, 4'h0, 4'h0, 16'h0080, 1'b0, ANS_OK},
            '{1'b0, OP_COMPUTE, 4'h0, 4'h0, 16'h0000, 1'b0, ANS_OK},
            '{1'b0, OP_WRITE_A, 4'h0, 4'h0, 16'hFFFF, 1'b0, ANS_OK},
            '{1'b0, OP_COMPUTE, 4'h0, 4'h0, 16'h0000, 1'b0, ANS_OK},
            '{1'b0, OP_WRITE_A, 4'hF, 4'hF, 16'h8000, 1'b1, ANS_ERR},
            '{1'b0, OP_WRITE_B, 4'h0, 4'hF, 16'hFFFF, 1'b1, ANS_ERR},
            '{1'b0, OP_COMPUTE, 4'hF, 4'h0, 16'hFFFF, 1'b1, ANS_ERR},
            '{1'b0, OP_SPARE,   4'h0, 4'h0, 16'h7FFF, 1'b1, ANS_ERR},
            '{1'b1, CFG_INNER,  4'h0, 4'h0, 16'h0000, 1'b0, ANS_OK},
            '{1'b0, OP_WRITE_A, 4'h0, 4'h0, 16'h1234, 1'b1, ANS_ERR},
            '{1'b0, OP_COMPUTE, 4'h0, 4'h0, 16'h0000, 1'b1, ANS_OK},
            '{1'b1, CFG_SPARE,  4'h0, 4'h0, 16'h001F, 1'b0, ANS_OK},
            '{1'b0, OP_COMPUTE, 4'h0, 4'h0, 16'h0000, 1'b1, ANS_OK},
            '{1'b1, CFG_ROWS_A, 4'h0, 4'h0, 16'h001F, 1'b0, ANS_OK},
            '{1'b1, CFG_INNER,  4'h0, 4'h0, 16'h001F, 1'b0, ANS_OK},
            '{1'b1, CFG_COLS_B, 4'h0, 4'h0, 16'h001F, 1'b0, ANS_OK},
            '{1'b0, OP_WRITE_A, 4'hF, 4'hF, 16'h7FFF, 1'b1, ANS_OK},
            '{1'b0, OP_WRITE_B, 4'hF, 4'hF, 16'h8000, 1'b1, ANS_OK},
            '{1'b0, OP_WRITE_B, 4'h0, 4'hF, 16'h0000, 1'b1, ANS_OK}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sender idles often, receiver stalls more often still.
        src_idle_pct = 37;
        snk_idle_pct = 61;
        foreach (script[i]) begin
            if (script[i].is_cfg)
                write_size(script[i].code, script[i].value[CFG_W-1:0]);
            else
                send_item(script[i].code, script[i].row, script[i].col, script[i].value,
                          script[i].typed, script[i].want);
        end
        while (items_sent < PHASE1_END)
            run_session();

        // Phase two: swap the rates.
        src_idle_pct = 61;
        snk_idle_pct = 37;
        while (items_sent < PHASE2_END)
            run_session();

        // Phase three: back-to-back on both sides.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        while (items_sent < ITEM_TARGET)
            run_session();

        await_answers();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d items in, %0d results checked, %0d size writes",
                 items_sent, answers_checked, size_writes);
        $display("%0d products (%0d clipped), %0d rejected items, %0d mismatches",
                 products_ok, products_sat, rejected_items, mismatch_count);
        if (mismatch_count == 0)
            $display("matrix_multiply_engine_unit verification clean");
        else
            $display("matrix_multiply_engine_unit verification failed");
        $finish;
    end

endmodule
